/* design/jfhp_pkg.sv */
package jfhp_pkg;

    localparam logic [1:0] KIND_HEADER    = 2'd0;
    localparam logic [1:0] KIND_COMPONENT = 2'd1;
    localparam logic [1:0] KIND_ERROR     = 2'd2;

    localparam logic [3:0] ST_OK          = 4'd0;
    localparam logic [3:0] ST_TRUNCATED   = 4'd1;
    localparam logic [3:0] ST_ZERO_WIDTH  = 4'd2;
    localparam logic [3:0] ST_PRECISION   = 4'd3;
    localparam logic [3:0] ST_COUNT       = 4'd4;
    localparam logic [3:0] ST_HORIZ       = 4'd5;
    localparam logic [3:0] ST_VERT        = 4'd6;
    localparam logic [3:0] ST_TABLE       = 4'd7;
    localparam logic [3:0] ST_UNSUPPORTED = 4'd8;

    localparam logic [3:0] FT_BASELINE       = 4'd0;
    localparam logic [3:0] FT_EXT_HUFF       = 4'd1;
    localparam logic [3:0] FT_PROG_HUFF      = 4'd2;
    localparam logic [3:0] FT_LOSSLESS_HUFF  = 4'd3;
    localparam logic [3:0] FT_EXT_ARITH      = 4'd9;
    localparam logic [3:0] FT_PROG_ARITH     = 4'd10;
    localparam logic [3:0] FT_LOSSLESS_ARITH = 4'd11;

    localparam logic [2:0] POS_LEN_HI    = 3'd0;
    localparam logic [2:0] POS_LEN_LO    = 3'd1;
    localparam logic [2:0] POS_PRECISION = 3'd2;
    localparam logic [2:0] POS_HEIGHT_HI = 3'd3;
    localparam logic [2:0] POS_HEIGHT_LO = 3'd4;
    localparam logic [2:0] POS_WIDTH_HI  = 3'd5;
    localparam logic [2:0] POS_WIDTH_LO  = 3'd6;
    localparam logic [2:0] POS_COUNT     = 3'd7;

    localparam logic [1:0] PH_ID    = 2'd0;
    localparam logic [1:0] PH_SAMP  = 2'd1;
    localparam logic [1:0] PH_TABLE = 2'd2;

    localparam logic [7:0] PREC_BASE      = 8'd8;
    localparam logic [7:0] PREC_EXT       = 8'd12;
    localparam logic [7:0] PREC_LL_MIN    = 8'd2;
    localparam logic [7:0] PREC_LL_MAX    = 8'd16;
    localparam logic [7:0] MAX_PROG_COMPS = 8'd4;
    localparam logic [3:0] MAX_FACTOR     = 4'd4;
    localparam logic [7:0] MAX_TABLE      = 8'd3;

    localparam int TDATA_W = 96;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  status;
        logic [15:0] seg_len;
        logic [7:0]  precision;
        logic [15:0] height;
        logic [15:0] width;
        logic [7:0]  comp_count;
        logic [7:0]  comp_id;
        logic [3:0]  h_factor;
        logic [3:0]  v_factor;
        logic [7:0]  quant_table;
        logic        last;
    } result_t;

    function automatic logic [3:0] header_status(input logic [15:0] w, input logic [3:0] ft,
                                                 input logic [7:0] p, input logic [7:0] c);
        logic [3:0] st;
        st = ST_OK;
        if (w == 16'd0) begin
            st = ST_ZERO_WIDTH;
        end else begin
            unique case (ft)
                FT_BASELINE: begin
                    if (p != PREC_BASE) st = ST_PRECISION;
                    else if (c == 8'd0) st = ST_COUNT;
                end
                FT_EXT_HUFF, FT_EXT_ARITH: begin
                    if (p != PREC_BASE && p != PREC_EXT) st = ST_PRECISION;
                    else if (c == 8'd0) st = ST_COUNT;
                end
                FT_PROG_HUFF, FT_PROG_ARITH: begin
                    if (p != PREC_BASE && p != PREC_EXT) st = ST_PRECISION;
                    else if (c == 8'd0 || c > MAX_PROG_COMPS) st = ST_COUNT;
                end
                FT_LOSSLESS_HUFF, FT_LOSSLESS_ARITH: begin
                    if (p < PREC_LL_MIN || p > PREC_LL_MAX) st = ST_PRECISION;
                    else if (c == 8'd0) st = ST_COUNT;
                end
                default: st = ST_UNSUPPORTED;
            endcase
        end
        return st;
    endfunction

    function automatic logic [3:0] component_status(input logic [3:0] ft, input logic [7:0] samp,
                                                    input logic [7:0] tq);
        logic [3:0] st;
        logic       lossless;
        st = ST_OK;
        lossless = (ft == FT_LOSSLESS_HUFF) || (ft == FT_LOSSLESS_ARITH);
        if (samp[7:4] == 4'd0 || samp[7:4] > MAX_FACTOR) st = ST_HORIZ;
        else if (samp[3:0] == 4'd0 || samp[3:0] > MAX_FACTOR) st = ST_VERT;
        else if (lossless && tq != 8'd0) st = ST_TABLE;
        else if (!lossless && tq > MAX_TABLE) st = ST_TABLE;
        return st;
    endfunction

endpackage

/* design/jpeg_frame_header_parser_unit.sv */
// A result is in the output register in the cycle after the item that causes it is accepted.
// Throughput: one segment byte per cycle; s_tready drops only while a result waits
// in the output register and m_tready is low.
// Reset (aresetn low, synchronous): the parser ignores bytes until one arrives with
// segment_start set, and the output register is emptied.
module jpeg_frame_header_parser_unit (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // data_byte
    input  logic [7:0]                   s_tdata,
    // segment_start, frame_type
    input  logic [4:0]                   s_tuser,
    input  logic                         s_tlast,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // status, segment_length, precision, height, width, component_count,
    // descriptor_id, horizontal_factor, vertical_factor, quant_table, zero pad
    output logic [jfhp_pkg::TDATA_W-1:0] m_tdata,
    // result_kind
    output logic [1:0]                   m_tuser,
    output logic                         m_tlast
);

    logic        skip_reg, skip_next;
    logic [2:0]  pos_reg, pos_next;
    logic        comp_reg, comp_next;
    logic [1:0]  phase_reg, phase_next;
    logic [15:0] len_reg, len_next;
    logic [7:0]  prec_reg, prec_next;
    logic [15:0] height_reg, height_next;
    logic [15:0] width_reg, width_next;
    logic [7:0]  count_reg, count_next;
    logic [3:0]  type_reg, type_next;
    logic [7:0]  left_reg, left_next;
    logic [7:0]  id_reg, id_next;
    logic [7:0]  samp_reg, samp_next;

    logic              accept;
    logic              start;
    logic              active;
    logic              res_valid;
    logic [3:0]        st;
    logic [7:0]        left_dec;
    jfhp_pkg::result_t res;

    assign accept = s_tvalid && s_tready;
    assign start  = accept && s_tuser[0];
    assign active = accept && (s_tuser[0] || !skip_reg);

    always_comb begin
        skip_next   = skip_reg;
        pos_next    = start ? jfhp_pkg::POS_LEN_HI : pos_reg;
        comp_next   = start ? 1'b0 : comp_reg;
        phase_next  = phase_reg;
        len_next    = len_reg;
        prec_next   = start ? 8'd0 : prec_reg;
        height_next = start ? 16'd0 : height_reg;
        width_next  = start ? 16'd0 : width_reg;
        count_next  = start ? 8'd0 : count_reg;
        type_next   = start ? s_tuser[4:1] : type_reg;
        left_next   = left_reg;
        id_next     = id_reg;
        samp_next   = samp_reg;
        res_valid   = 1'b0;
        st          = jfhp_pkg::ST_OK;
        left_dec    = left_reg;
        res.kind    = jfhp_pkg::KIND_ERROR;
        res.status  = jfhp_pkg::ST_TRUNCATED;
        res.comp_id     = 8'd0;
        res.h_factor    = 4'd0;
        res.v_factor    = 4'd0;
        res.quant_table = 8'd0;
        res.last        = 1'b1;
        if (active) begin
            skip_next = 1'b0;
            if (!comp_next) begin
                if (pos_next != jfhp_pkg::POS_COUNT) begin
                    unique case (pos_next)
                        jfhp_pkg::POS_LEN_HI:    len_next    = {s_tdata, 8'd0};
                        jfhp_pkg::POS_LEN_LO:    len_next    = {len_next[15:8], s_tdata};
                        jfhp_pkg::POS_PRECISION: prec_next   = s_tdata;
                        jfhp_pkg::POS_HEIGHT_HI: height_next = {s_tdata, 8'd0};
                        jfhp_pkg::POS_HEIGHT_LO: height_next = {height_next[15:8], s_tdata};
                        jfhp_pkg::POS_WIDTH_HI:  width_next  = {s_tdata, 8'd0};
                        default:                 width_next  = {width_next[15:8], s_tdata};
                    endcase
                    pos_next = pos_next + 3'd1;
                    if (s_tlast) begin
                        res_valid = 1'b1;
                        skip_next = 1'b1;
                    end
                end else begin
                    count_next = s_tdata;
                    left_next  = s_tdata;
                    comp_next  = 1'b1;
                    phase_next = jfhp_pkg::PH_ID;
                    res_valid  = 1'b1;
                    st = jfhp_pkg::header_status(width_next, type_next, prec_next, s_tdata);
                    if (s_tlast && s_tdata != 8'd0) begin
                        skip_next = 1'b1;
                    end else if (st != jfhp_pkg::ST_OK) begin
                        res.status = st;
                        skip_next  = 1'b1;
                    end else begin
                        res.kind   = jfhp_pkg::KIND_HEADER;
                        res.status = jfhp_pkg::ST_OK;
                        res.last   = 1'b0;
                    end
                end
            end else begin
                unique case (phase_reg)
                    jfhp_pkg::PH_ID: begin
                        id_next    = s_tdata;
                        phase_next = jfhp_pkg::PH_SAMP;
                        if (s_tlast) begin
                            res_valid = 1'b1;
                            skip_next = 1'b1;
                        end
                    end
                    jfhp_pkg::PH_SAMP: begin
                        samp_next  = s_tdata;
                        phase_next = jfhp_pkg::PH_TABLE;
                        if (s_tlast) begin
                            res_valid = 1'b1;
                            skip_next = 1'b1;
                        end
                    end
                    default: begin
                        phase_next = jfhp_pkg::PH_ID;
                        left_dec   = (left_reg != 8'd0) ? left_reg - 8'd1 : left_reg;
                        left_next  = left_dec;
                        res_valid  = 1'b1;
                        st = jfhp_pkg::component_status(type_reg, samp_reg, s_tdata);
                        if (s_tlast && left_dec != 8'd0) begin
                            skip_next = 1'b1;
                        end else if (st != jfhp_pkg::ST_OK) begin
                            res.status = st;
                            skip_next  = 1'b1;
                        end else begin
                            res.kind        = jfhp_pkg::KIND_COMPONENT;
                            res.status      = jfhp_pkg::ST_OK;
                            res.comp_id     = id_reg;
                            res.h_factor    = samp_reg[7:4];
                            res.v_factor    = samp_reg[3:0];
                            res.quant_table = s_tdata;
                            res.last        = (left_dec == 8'd0);
                            skip_next       = (left_dec == 8'd0);
                        end
                    end
                endcase
            end
        end
        res.seg_len    = len_next;
        res.precision  = prec_next;
        res.height     = height_next;
        res.width      = width_next;
        res.comp_count = count_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skip_reg  <= 1'b1;
            pos_reg   <= jfhp_pkg::POS_LEN_HI;
            comp_reg  <= 1'b0;
            phase_reg <= jfhp_pkg::PH_ID;
        end else begin
            skip_reg  <= skip_next;
            pos_reg   <= pos_next;
            comp_reg  <= comp_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        len_reg    <= len_next;
        prec_reg   <= prec_next;
        height_reg <= height_next;
        width_reg  <= width_next;
        count_reg  <= count_next;
        type_reg   <= type_next;
        left_reg   <= left_next;
        id_reg     <= id_next;
        samp_reg   <= samp_next;
    end

    jfhp_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (res_valid),
        .in_res   (res),
        .in_ready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

/* design/jfhp_out_reg.sv */
module jfhp_out_reg (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_valid,
    input  jfhp_pkg::result_t              in_res,
    output logic                           in_ready,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // status, segment_length, precision, height, width, component_count,
    // descriptor_id, horizontal_factor, vertical_factor, quant_table, zero pad
    output logic [jfhp_pkg::TDATA_W-1:0]   m_tdata,
    // result_kind
    output logic [1:0]                     m_tuser,
    output logic                           m_tlast
);

    logic              valid_reg;
    logic              valid_next;
    jfhp_pkg::result_t res_reg;

    assign in_ready = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (in_valid) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid) begin
            res_reg <= in_res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = res_reg.kind;
    assign m_tlast  = res_reg.last;
    assign m_tdata  = {4'd0, res_reg.quant_table, res_reg.v_factor, res_reg.h_factor,
                       res_reg.comp_id, res_reg.comp_count, res_reg.width, res_reg.height,
                       res_reg.precision, res_reg.seg_len, res_reg.status};

endmodule

/* design/jfhp_checker.sv */
module jfhp_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_tready,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [jfhp_pkg::TDATA_W-1:0] m_tdata,
    input logic [1:0]                   m_tuser,
    input logic                         m_tlast
);

    // The output register is empty after reset.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A result that is not taken stays unchanged.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                   && $stable(m_tlast))
        else $error("stalled result changed");

    // Input is taken whenever the output register is free.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output register");

    // Every error closes the segment.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == jfhp_pkg::KIND_ERROR
            |-> m_tlast && m_tdata[3:0] != jfhp_pkg::ST_OK)
        else $error("error result without last or with ok status");

    // A header result carries an ok status and never closes the segment.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == jfhp_pkg::KIND_HEADER
            |-> !m_tlast && m_tdata[3:0] == jfhp_pkg::ST_OK)
        else $error("bad header result");

endmodule

bind jpeg_frame_header_parser_unit jfhp_checker u_jfhp_checker (.*);
